/* rtl/ctme_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the color tolerance mask edges unit.
// No dependencies; used by the top level and the checker.
package ctme_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_SIZE_W = 11;
  localparam int unsigned CFG_THR_W  = 8;
  localparam int unsigned POS_W      = 10;

  typedef enum logic [1:0] {
    CFG_TARGET_COLOR = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_RECT_WIDTH   = 2'd2,
    CFG_RECT_HEIGHT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } ctme_in_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             mask;
    logic             edge_top;
    logic             edge_left;
    logic             edge_right_of_left;
    logic             edge_bottom_of_above;
    logic             edge_right_here;
    logic             edge_bottom_here;
    logic             frame_last;
  } ctme_out_t;

endpackage

/* rtl/ctme_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ctme_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/color_tolerance_mask_edges_unit.sv */
`timescale 1ns / 1ps
// Top level of the color tolerance mask edges unit.
// Depends on ctme_pkg and ctme_ram (previous-row mask line buffer).
//
//   channel  direction  handshake                 beat payload
//   in       input      in_valid_i / in_ready_o   ctme_in_t   (one RGBA pixel)
//   out      output     out_valid_o / out_ready_i ctme_out_t  (position, mask, edges)
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One pixel per clock while the output does not stall; an accepted pixel passes the middle
// stage, which waits on the line buffer read, and then the output register, into which the
// edges are formed.
// The line buffer write of a pixel and the read for the next pixel can share a cycle;
// a matching address is forwarded from the write side.
// Reset clears counters and valid flags; the line buffer holds no reset state.
// An output stall holds the middle stage, and input is taken whenever it can move.
module color_tolerance_mask_edges_unit
  import ctme_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ctme_in_t              in_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctme_out_t             out_result_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
  localparam int unsigned SH = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;

  logic [CFG_DATA_W-1:0] target_q;
  logic [CFG_THR_W-1:0]  thr_q;
  logic [CFG_SIZE_W-1:0] rect_w_q;
  logic [CFG_SIZE_W-1:0] rect_h_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          left_q;

  logic          s1_valid_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_mask_q;
  logic          s1_last_col_q;
  logic          s1_last_row_q;
  logic          fwd_q;
  logic          fwd_val_q;

  logic          out_valid_q;
  ctme_out_t     out_q, out_d;

  logic          in_fire, s1_fire;
  logic [SW-1:0] w_eff;
  logic [SH-1:0] h_eff;
  logic          last_col, last_row, pix_mask;
  logic          line_bit, above, left;
  logic [31:0]   col_ext, row_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      thr_q    <= '0;
      rect_w_q <= CFG_SIZE_W'(1);
      rect_h_q <= CFG_SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_COLOR: target_q <= cfg_wdata_i;
        CFG_THRESHOLD:    thr_q    <= cfg_wdata_i[CFG_THR_W-1:0];
        CFG_RECT_WIDTH:   rect_w_q <= cfg_wdata_i[CFG_SIZE_W-1:0];
        CFG_RECT_HEIGHT:  rect_h_q <= cfg_wdata_i[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (rect_w_q == '0) begin
      w_eff = SW'(1);
    end else if (SW'(rect_w_q) > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(rect_w_q);
    end
    priority if (rect_h_q == '0) begin
      h_eff = SH'(1);
    end else if (SH'(rect_h_q) > SH'(MAX_HEIGHT)) begin
      h_eff = SH'(MAX_HEIGHT);
    end else begin
      h_eff = SH'(rect_h_q);
    end
  end

  assign last_col = (SW'(col_q) + SW'(1)) >= w_eff;
  assign last_row = (SH'(row_q) + SH'(1)) >= h_eff;

  always_comb begin
    logic [CHAN_W-1:0] pix [4];
    logic [CHAN_W-1:0] tgt [4];
    logic [CHAN_W-1:0] diff;
    pix[0] = in_pixel_i.red;
    pix[1] = in_pixel_i.green;
    pix[2] = in_pixel_i.blue;
    pix[3] = in_pixel_i.alpha;
    tgt[0] = target_q[31:24];
    tgt[1] = target_q[23:16];
    tgt[2] = target_q[15:8];
    tgt[3] = target_q[7:0];
    pix_mask = 1'b0;
    for (int i = 0; i < 4; i++) begin
      diff = (pix[i] > tgt[i]) ? (pix[i] - tgt[i]) : (tgt[i] - pix[i]);
      if (diff > thr_q) begin
        pix_mask = 1'b1;
      end
    end
  end

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s1_fire) begin
        left_q <= s1_last_col_q ? 1'b0 : s1_mask_q;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_mask_q     <= pix_mask;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
      fwd_q         <= s1_fire && (s1_col_q == col_q);
      fwd_val_q     <= s1_mask_q;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  ctme_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (s1_fire),
    .waddr_i(s1_col_q),
    .wdata_i(s1_mask_q),
    .re_i   (in_fire),
    .raddr_i(col_q),
    .rdata_o(line_bit)
  );

  assign above   = (s1_row_q != '0) && (fwd_q ? fwd_val_q : line_bit);
  assign left    = (s1_col_q != '0) && left_q;
  assign col_ext = 32'(s1_col_q);
  assign row_ext = 32'(s1_row_q);

  always_comb begin
    out_d.col                  = col_ext[POS_W-1:0];
    out_d.row                  = row_ext[POS_W-1:0];
    out_d.mask                 = s1_mask_q;
    out_d.edge_top             = s1_mask_q && !above;
    out_d.edge_left            = s1_mask_q && !left;
    out_d.edge_right_of_left   = left && !s1_mask_q;
    out_d.edge_bottom_of_above = above && !s1_mask_q;
    out_d.edge_right_here      = s1_mask_q && s1_last_col_q;
    out_d.edge_bottom_here     = s1_mask_q && s1_last_row_q;
    out_d.frame_last           = s1_last_col_q && s1_last_row_q;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

/* rtl/ctme_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the color tolerance mask edges unit, bound to the top level.
// Depends on ctme_pkg.
module ctme_checker
  import ctme_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ctme_out_t out_result_o
);

  logic beat;
  assign beat = out_valid_o && out_ready_i;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_result_o))
    else $error("output beat changed while stalled");

  // Edges of the pixel itself appear only on masked pixels.
  a_own_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !out_result_o.mask |-> !out_result_o.edge_top && !out_result_o.edge_left
      && !out_result_o.edge_right_here && !out_result_o.edge_bottom_here)
    else $error("own edge flagged on an unmasked pixel");

  // In the first column the left edge follows the mask and no neighbour edge exists.
  a_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && out_result_o.col == '0 |->
      out_result_o.edge_left == out_result_o.mask && !out_result_o.edge_right_of_left)
    else $error("wrong left edges in the first column");

  // In the first row the top edge follows the mask and no edge from above exists.
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && out_result_o.row == '0 |->
      out_result_o.edge_top == out_result_o.mask && !out_result_o.edge_bottom_of_above)
    else $error("wrong top edges in the first row");

endmodule

bind color_tolerance_mask_edges_unit ctme_checker u_ctme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_result_o(out_result_o)
);
